/* hdl/fnvh_pkg.sv */
package fnvh_pkg;

    // one byte of the string with its flags
    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_char;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic [63:0] hash_value;
    } hash_item_t;

    localparam logic [63:0] BASIS32 = 64'h0000_0000_811C_9DC5;
    localparam logic [63:0] BASIS64 = 64'hCBF2_9CE4_8422_2325;

    // primes split as 2^shift + small low part
    localparam int unsigned PRIME32_SHIFT = 24;
    localparam logic [8:0]  PRIME32_LO    = 9'h193;
    localparam int unsigned PRIME64_SHIFT = 40;
    localparam logic [8:0]  PRIME64_LO    = 9'h1B3;

    // case folding by the plain ascii rule
    localparam logic [7:0] LOWER_A   = 8'h61;
    localparam logic [7:0] LOWER_Z   = 8'h7A;
    localparam logic [7:0] CASE_DIFF = 8'h20;

endpackage

/* hdl/fnvh_stream_if.sv */
interface fnvh_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/fnvh_front.sv */
module fnvh_front (
    fnvh_stream_if.sink   char_in,
    fnvh_stream_if.source item
);

    logic       is_lower;
    logic       keep;
    logic [7:0] folded;

    assign is_lower = (char_in.data.char_byte >= fnvh_pkg::LOWER_A)
                   && (char_in.data.char_byte <= fnvh_pkg::LOWER_Z);
    assign folded   = is_lower ? (char_in.data.char_byte - fnvh_pkg::CASE_DIFF)
                               : char_in.data.char_byte;

    // a transaction with neither a character nor an end mark changes nothing
    assign keep = char_in.data.has_char || char_in.data.last;

    assign item.valid          = char_in.valid && keep;
    assign item.data.char_byte = folded;
    assign item.data.has_char  = char_in.data.has_char;
    assign item.data.last      = char_in.data.last;
    assign char_in.ready       = item.ready;

endmodule

/* hdl/fnvh_queue.sv */
module fnvh_queue #(
    parameter int DEPTH = 2
) (
    input logic           clk,
    input logic           rst_n,
    fnvh_stream_if.sink   wr,
    fnvh_stream_if.source rd
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fnvh_pkg::char_item_t entry_reg [DEPTH];
    logic [IDX_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 push;
    logic                 pop;

    assign wr.ready = (count_reg != CNT_W'(DEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.data  = entry_reg[rd_ptr_reg];

    assign push = wr.valid && wr.ready;
    assign pop  = rd.valid && rd.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr.data;
        end
    end

endmodule

/* hdl/fnvh_back.sv */
module fnvh_back (
    input  logic          clk,
    input  logic          rst_n,
    fnvh_stream_if.sink   item,
    fnvh_stream_if.source hash_out,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    output logic          wide_mode
);

    logic [63:0] hash_reg;
    logic        wide_mode_reg;
    logic        out_valid_reg;
    logic [63:0] out_hash_reg;

    logic [63:0] mixed;
    logic [63:0] prod64;
    logic [31:0] prod32;
    logic [63:0] stepped;
    logic [63:0] finished;
    logic        pop;

    // xor then multiply by 2^shift + lo, wrapping at the mode width
    assign mixed    = hash_reg ^ {56'b0, item.data.char_byte};
    assign prod64   = (mixed << fnvh_pkg::PRIME64_SHIFT)
                    + (mixed * 64'(fnvh_pkg::PRIME64_LO));
    assign prod32   = (mixed[31:0] << fnvh_pkg::PRIME32_SHIFT)
                    + (mixed[31:0] * 32'(fnvh_pkg::PRIME32_LO));
    assign stepped  = !item.data.has_char ? hash_reg
                    : (wide_mode_reg ? prod64 : {32'b0, prod32});
    assign finished = wide_mode_reg ? stepped : {32'b0, stepped[31:0]};

    // a final transaction needs room in the output register
    assign item.ready = !item.data.last || !out_valid_reg || hash_out.ready;
    assign pop        = item.valid && item.ready;

    assign hash_out.valid           = out_valid_reg;
    assign hash_out.data.hash_value = out_hash_reg;
    assign wide_mode                = wide_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_mode_reg <= 1'b1;
            hash_reg      <= fnvh_pkg::BASIS64;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                wide_mode_reg <= cfg_wr_data;
                hash_reg      <= cfg_wr_data ? fnvh_pkg::BASIS64 : fnvh_pkg::BASIS32;
            end
            else if (pop)
            begin
                if (item.data.last)
                begin
                    hash_reg <= wide_mode_reg ? fnvh_pkg::BASIS64 : fnvh_pkg::BASIS32;
                end
                else
                begin
                    hash_reg <= stepped;
                end
            end

            if (pop && item.data.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (hash_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && item.data.last)
        begin
            out_hash_reg <= finished;
        end
    end

endmodule

/* hdl/fnv1a_nocase_hash.sv */
// Case-insensitive FNV-1a hash over a byte stream, one byte per transaction on
// char_in; a transaction with last set returns the finished hash on hash_out
// and restarts from the offset basis (has_char low with last set hashes the
// empty string). Bytes a-z fold to A-Z first. cfg_wr_data selects 64-bit (1,
// the reset value) or 32-bit (0) mode; each write restarts the hash and must
// be done while the block is idle. The block sustains one byte per clock while
// hash_out takes its results: the front end folds bytes into a small queue and
// the back end runs the xor and constant multiply in a loop on the registered
// running hash; each hash is registered on hash_out as its last byte is popped.
module fnv1a_nocase_hash #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    fnvh_stream_if.sink   char_in,
    fnvh_stream_if.source hash_out,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data
);

    fnvh_stream_if #(.payload_t(fnvh_pkg::char_item_t)) front_q ();
    fnvh_stream_if #(.payload_t(fnvh_pkg::char_item_t)) back_q ();

    logic wide_mode;

    fnvh_front u_front (
        .char_in (char_in),
        .item    (front_q)
    );

    fnvh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (front_q),
        .rd    (back_q)
    );

    fnvh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (back_q),
        .hash_out    (hash_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .wide_mode   (wide_mode)
    );

    a_narrow_upper_zero : assert property (@(posedge clk) disable iff (!rst_n)
        hash_out.valid && !wide_mode |-> hash_out.data.hash_value[63:32] == 32'b0)
        else $error("32-bit mode hash has upper bits set");

    a_mode_follows_write : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> wide_mode == $past(cfg_wr_data))
        else $error("mode register did not take the written value");

    a_output_drains : assert property (@(posedge clk) disable iff (!rst_n)
        hash_out.valid && hash_out.ready && !(back_q.valid && back_q.ready)
        |=> !hash_out.valid)
        else $error("result register stayed full after its transaction");

endmodule
